// ===== sv/ies_pkg.sv =====
// Shared types, constants and helper functions of the image error statistics block.
package ies_pkg;

    localparam int C_CHANNELS      = 4;
    localparam int C_COLOR_CH      = 3;
    localparam int C_BINS          = 9;
    localparam int C_BIN_W         = 4;
    localparam int C_TILE_SIDE     = 4;
    localparam int C_MAX_DIMENSION = 16384;
    localparam int C_COORD_W       = 14;
    localparam logic [C_COORD_W-1:0] C_COORD_LIMIT =
        C_COORD_W'(C_MAX_DIMENSION - C_TILE_SIDE);

    localparam int C_HIST_COLOR_W  = 30;
    localparam int C_HIST_OPA_W    = 29;
    localparam int C_HIST_ALL_W    = 31;
    localparam int C_ABS_COLOR_W   = 38;
    localparam int C_SQ_COLOR_W    = 46;
    localparam int C_ABS_OPA_W     = 37;
    localparam int C_ABS_OPA_OUT_W = 36;
    localparam int C_SQ_OPA_W      = 44;
    localparam int C_TILE_SQ_W     = 22;
    localparam int C_TILE_CNT_W    = 7;
    localparam int C_PROD_W        = C_TILE_SQ_W + C_TILE_CNT_W;

    typedef struct packed {
        logic [7:0]           first_red;
        logic [7:0]           first_green;
        logic [7:0]           first_blue;
        logic [7:0]           first_alpha;
        logic [7:0]           second_red;
        logic [7:0]           second_green;
        logic [7:0]           second_blue;
        logic [7:0]           second_alpha;
        logic [C_COORD_W-1:0] tile_column;
        logic [C_COORD_W-1:0] tile_row;
        logic                 tile_end;
        logic                 image_end;
    } t_pixel_pair;

    typedef struct packed {
        logic [C_BIN_W-1:0]         bin_index;
        logic [C_HIST_COLOR_W-1:0]  count_color;
        logic [C_HIST_OPA_W-1:0]    count_opacity;
        logic [C_HIST_ALL_W-1:0]    count_all;
        logic [C_ABS_COLOR_W-1:0]   abs_sum_color;
        logic [C_SQ_COLOR_W-1:0]    square_sum_color;
        logic [C_ABS_OPA_OUT_W-1:0] abs_sum_opacity;
        logic [C_SQ_OPA_W-1:0]      square_sum_opacity;
        logic                       opacity_constant;
        logic [C_COORD_W-1:0]       worst_column;
        logic [C_COORD_W-1:0]       worst_row;
        logic                       report_last;
    } t_report;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_ACCUM,
        S_COMPARE,
        S_DECIDE,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic load;
        logic diff;
        logic accum;
        logic compare;
        logic decide;
        logic next_bin;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic tile_close;
        logic image_end;
        logic last_bin;
    } t_status;

    function automatic logic [C_BIN_W-1:0] bit_length(input logic [7:0] v);
        logic [C_BIN_W-1:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) begin
                n = C_BIN_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// ===== sv/ies_stream_if.sv =====
// Valid/ready stream interface that carries one item per handshake.
interface ies_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/ies_ctrl.sv =====
// Sequencer that steps each pixel pair through the datapath and walks the report bins.
module ies_ctrl import ies_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_ACCUM;
            end
            S_ACCUM: begin
                o_cmd.accum = 1'b1;
                n_state     = i_status.tile_close ? S_COMPARE : S_IDLE;
            end
            S_COMPARE: begin
                o_cmd.compare = 1'b1;
                n_state       = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_status.image_end ? S_REPORT : S_IDLE;
            end
            S_REPORT: begin
                o_out_valid = i_rst_n;
                if (i_out_ready && i_rst_n) begin
                    o_cmd.next_bin = 1'b1;
                    if (i_status.last_bin) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/ies_datapath.sv =====
// Error accumulators, bit-length histograms and worst-tile tracking.
module ies_datapath import ies_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_pixel_pair i_pixel,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output t_report     o_report
);

    t_pixel_pair r_in;
    logic [7:0]  r_diff [C_CHANNELS];
    logic [15:0] r_sq   [C_CHANNELS];
    logic [C_BIN_W-1:0] r_len [C_CHANNELS];
    logic [C_PROD_W-1:0] r_prod_tile;
    logic [C_PROD_W-1:0] r_prod_worst;

    logic [C_ABS_COLOR_W-1:0] r_color_abs, n_color_abs;
    logic [C_SQ_COLOR_W-1:0]  r_color_sq, n_color_sq;
    logic [C_ABS_OPA_W-1:0]   r_opa_abs, n_opa_abs;
    logic [C_SQ_OPA_W-1:0]    r_opa_sq, n_opa_sq;
    logic [C_HIST_COLOR_W-1:0] r_hist_color [C_BINS];
    logic [C_HIST_COLOR_W-1:0] n_hist_color [C_BINS];
    logic [C_HIST_OPA_W-1:0]   r_hist_opa   [C_BINS];
    logic [C_HIST_OPA_W-1:0]   n_hist_opa   [C_BINS];
    logic [C_HIST_ALL_W-1:0]   r_hist_all   [C_BINS];
    logic [C_HIST_ALL_W-1:0]   n_hist_all   [C_BINS];
    logic [C_TILE_SQ_W-1:0]   r_tile_sq, n_tile_sq;
    logic [C_TILE_CNT_W-1:0]  r_tile_cnt, n_tile_cnt;
    logic [C_TILE_SQ_W-1:0]   r_worst_sq;
    logic [C_TILE_CNT_W-1:0]  r_worst_cnt;
    logic [C_COORD_W-1:0]     r_worst_x;
    logic [C_COORD_W-1:0]     r_worst_y;
    logic                     r_worst_valid;
    logic                     r_alpha_max;
    logic [C_BIN_W-1:0]       r_bin;

    logic [7:0] ch_first  [C_CHANNELS];
    logic [7:0] ch_second [C_CHANNELS];
    logic [7:0] ch_diff   [C_CHANNELS];

    logic [9:0]  color_abs_inc;
    logic [17:0] color_sq_inc;
    logic [18:0] tile_sq_inc;
    logic [C_ABS_COLOR_W:0] color_abs_sum;
    logic [C_SQ_COLOR_W:0]  color_sq_sum;
    logic [C_ABS_OPA_W:0]   opa_abs_sum;
    logic [C_SQ_OPA_W:0]    opa_sq_sum;
    logic [C_TILE_SQ_W:0]   tile_sq_sum;
    logic [C_TILE_CNT_W:0]  tile_cnt_sum;
    logic [1:0] inc_color [C_BINS];
    logic       inc_opa   [C_BINS];
    logic [2:0] inc_all   [C_BINS];
    logic [C_HIST_COLOR_W:0] sum_color [C_BINS];
    logic [C_HIST_OPA_W:0]   sum_opa   [C_BINS];
    logic [C_HIST_ALL_W:0]   sum_all   [C_BINS];
    logic       take;
    logic [C_COORD_W-1:0] clamp_x;
    logic [C_COORD_W-1:0] clamp_y;

    assign ch_first[0]  = r_in.first_red;
    assign ch_first[1]  = r_in.first_green;
    assign ch_first[2]  = r_in.first_blue;
    assign ch_first[3]  = r_in.first_alpha;
    assign ch_second[0] = r_in.second_red;
    assign ch_second[1] = r_in.second_green;
    assign ch_second[2] = r_in.second_blue;
    assign ch_second[3] = r_in.second_alpha;

    always_comb begin
        for (int c = 0; c < C_CHANNELS; c++) begin
            ch_diff[c] = (ch_first[c] > ch_second[c]) ? ch_first[c] - ch_second[c]
                                                      : ch_second[c] - ch_first[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_pixel;
        end
        if (i_cmd.diff) begin
            for (int c = 0; c < C_CHANNELS; c++) begin
                r_diff[c] <= ch_diff[c];
                r_sq[c]   <= 16'(ch_diff[c]) * 16'(ch_diff[c]);
                r_len[c]  <= bit_length(ch_diff[c]);
            end
        end
        if (i_cmd.compare) begin
            r_prod_tile  <= C_PROD_W'(r_tile_sq) * C_PROD_W'(r_worst_cnt);
            r_prod_worst <= C_PROD_W'(r_worst_sq) * C_PROD_W'(r_tile_cnt);
        end
    end

    always_comb begin
        color_abs_inc = 10'(r_diff[0]) + 10'(r_diff[1]) + 10'(r_diff[2]);
        color_sq_inc  = 18'(r_sq[0]) + 18'(r_sq[1]) + 18'(r_sq[2]);
        tile_sq_inc   = 19'(color_sq_inc) + 19'(r_sq[3]);

        color_abs_sum = {1'b0, r_color_abs} + (C_ABS_COLOR_W+1)'(color_abs_inc);
        color_sq_sum  = {1'b0, r_color_sq} + (C_SQ_COLOR_W+1)'(color_sq_inc);
        opa_abs_sum   = {1'b0, r_opa_abs} + (C_ABS_OPA_W+1)'(r_diff[3]);
        opa_sq_sum    = {1'b0, r_opa_sq} + (C_SQ_OPA_W+1)'(r_sq[3]);
        tile_sq_sum   = {1'b0, r_tile_sq} + (C_TILE_SQ_W+1)'(tile_sq_inc);
        tile_cnt_sum  = {1'b0, r_tile_cnt} + (C_TILE_CNT_W+1)'(C_CHANNELS);

        n_color_abs = color_abs_sum[C_ABS_COLOR_W] ? '1 : color_abs_sum[C_ABS_COLOR_W-1:0];
        n_color_sq  = color_sq_sum[C_SQ_COLOR_W] ? '1 : color_sq_sum[C_SQ_COLOR_W-1:0];
        n_opa_abs   = opa_abs_sum[C_ABS_OPA_W] ? '1 : opa_abs_sum[C_ABS_OPA_W-1:0];
        n_opa_sq    = opa_sq_sum[C_SQ_OPA_W] ? '1 : opa_sq_sum[C_SQ_OPA_W-1:0];
        n_tile_sq   = tile_sq_sum[C_TILE_SQ_W] ? '1 : tile_sq_sum[C_TILE_SQ_W-1:0];
        n_tile_cnt  = tile_cnt_sum[C_TILE_CNT_W] ? '1 : tile_cnt_sum[C_TILE_CNT_W-1:0];

        for (int b = 0; b < C_BINS; b++) begin
            inc_color[b] = 2'(r_len[0] == C_BIN_W'(b)) + 2'(r_len[1] == C_BIN_W'(b))
                         + 2'(r_len[2] == C_BIN_W'(b));
            inc_opa[b]   = (r_len[3] == C_BIN_W'(b));
            inc_all[b]   = 3'(inc_color[b]) + 3'(inc_opa[b]);
            sum_color[b] = {1'b0, r_hist_color[b]} + (C_HIST_COLOR_W+1)'(inc_color[b]);
            sum_opa[b]   = {1'b0, r_hist_opa[b]} + (C_HIST_OPA_W+1)'(inc_opa[b]);
            sum_all[b]   = {1'b0, r_hist_all[b]} + (C_HIST_ALL_W+1)'(inc_all[b]);
            n_hist_color[b] = sum_color[b][C_HIST_COLOR_W] ? '1
                                                           : sum_color[b][C_HIST_COLOR_W-1:0];
            n_hist_opa[b]   = sum_opa[b][C_HIST_OPA_W] ? '1 : sum_opa[b][C_HIST_OPA_W-1:0];
            n_hist_all[b]   = sum_all[b][C_HIST_ALL_W] ? '1 : sum_all[b][C_HIST_ALL_W-1:0];
        end
    end

    assign take    = !r_worst_valid || (r_prod_tile > r_prod_worst);
    assign clamp_x = (r_in.tile_column > C_COORD_LIMIT) ? C_COORD_LIMIT : r_in.tile_column;
    assign clamp_y = (r_in.tile_row > C_COORD_LIMIT) ? C_COORD_LIMIT : r_in.tile_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_color_abs   <= '0;
            r_color_sq    <= '0;
            r_opa_abs     <= '0;
            r_opa_sq      <= '0;
            r_tile_sq     <= '0;
            r_tile_cnt    <= '0;
            r_worst_sq    <= '0;
            r_worst_cnt   <= '0;
            r_worst_x     <= '0;
            r_worst_y     <= '0;
            r_worst_valid <= 1'b0;
            r_alpha_max   <= 1'b1;
            r_bin         <= '0;
            for (int b = 0; b < C_BINS; b++) begin
                r_hist_color[b] <= '0;
                r_hist_opa[b]   <= '0;
                r_hist_all[b]   <= '0;
            end
        end else begin
            if (i_cmd.accum) begin
                r_color_abs <= n_color_abs;
                r_color_sq  <= n_color_sq;
                r_opa_abs   <= n_opa_abs;
                r_opa_sq    <= n_opa_sq;
                r_tile_sq   <= n_tile_sq;
                r_tile_cnt  <= n_tile_cnt;
                if (r_in.first_alpha != 8'hFF || r_in.second_alpha != 8'hFF) begin
                    r_alpha_max <= 1'b0;
                end
                for (int b = 0; b < C_BINS; b++) begin
                    r_hist_color[b] <= n_hist_color[b];
                    r_hist_opa[b]   <= n_hist_opa[b];
                    r_hist_all[b]   <= n_hist_all[b];
                end
            end
            if (i_cmd.decide) begin
                if (take) begin
                    r_worst_sq    <= r_tile_sq;
                    r_worst_cnt   <= r_tile_cnt;
                    r_worst_x     <= clamp_x;
                    r_worst_y     <= clamp_y;
                    r_worst_valid <= 1'b1;
                end
                r_tile_sq  <= '0;
                r_tile_cnt <= '0;
            end
            if (i_cmd.next_bin) begin
                r_bin <= r_bin + C_BIN_W'(1);
            end
        end
    end

    assign o_status.tile_close = r_in.tile_end | r_in.image_end;
    assign o_status.image_end  = r_in.image_end;
    assign o_status.last_bin   = (r_bin == C_BIN_W'(C_BINS - 1));

    always_comb begin
        o_report.bin_index          = r_bin;
        o_report.count_color        = r_hist_color[r_bin];
        o_report.count_opacity      = r_hist_opa[r_bin];
        o_report.count_all          = r_hist_all[r_bin];
        o_report.abs_sum_color      = r_color_abs;
        o_report.square_sum_color   = r_color_sq;
        o_report.abs_sum_opacity    = r_opa_abs[C_ABS_OPA_W-1] ? '1
                                                               : r_opa_abs[C_ABS_OPA_OUT_W-1:0];
        o_report.square_sum_opacity = r_opa_sq;
        o_report.opacity_constant   = r_alpha_max;
        o_report.worst_column       = r_worst_x;
        o_report.worst_row          = r_worst_y;
        o_report.report_last        = o_status.last_bin;
    end

    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bin <= C_BIN_W'(C_BINS - 1))
        else $error("Report bin counter ran past the last bin.");

    a_decide_closes_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.decide |=> r_worst_valid && r_tile_sq == '0 && r_tile_cnt == '0)
        else $error("Closing a tile did not leave a worst tile and an empty tile.");

    a_clear_restores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> r_bin == '0 && r_alpha_max && !r_worst_valid && r_color_sq == '0)
        else $error("End of report did not return the statistics to their reset values.");

endmodule

// ===== sv/image_error_statistics.sv =====
// Top level of the image error statistics block.
//
//   Channel   Direction  Payload       Carries
//   i_pixel   in         t_pixel_pair  one pixel pair with tile corner and end flags
//   o_report  out        t_report      one histogram bin with the image totals
//
// The sequencer runs the load, difference and accumulate steps on one pixel pair at a
// time, adding the multiply and compare steps when the pair closes a tile.
// The last pixel of an image is followed by nine report items, one per cycle while
// o_report.ready is high; no pixel is taken until the ninth item has gone.
// Reset and the end of each report clear all sums, histograms and the worst tile.
module image_error_statistics import ies_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ies_stream_if.sink   i_pixel,
    ies_stream_if.source o_report
);

    t_cmd    cmd;
    t_status status;
    logic    in_ready;
    logic    out_valid;
    t_report report_data;

    ies_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pixel.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_report.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ies_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pixel  (i_pixel.data),
        .i_cmd    (cmd),
        .o_status (status),
        .o_report (report_data)
    );

    assign i_pixel.ready  = in_ready;
    assign o_report.valid = out_valid;
    assign o_report.data  = report_data;

endmodule
